FILE: design/alu64_pkg.sv
// alu64_pkg: opcodes and the pipeline control struct for the 64-bit ALU.
// Used by every module in the design folder; no dependencies.
`timescale 1ns / 1ps
package alu64_pkg;
   localparam int DATA_WIDTH_DEF = 64;
   localparam int CMD_WIDTH      = 5;
   localparam int COUNT_WIDTH    = 64;

   localparam logic [CMD_WIDTH-1:0] OP_ADD = 5'd0;
   localparam logic [CMD_WIDTH-1:0] OP_SUB = 5'd1;
   localparam logic [CMD_WIDTH-1:0] OP_MUL = 5'd2;
   localparam logic [CMD_WIDTH-1:0] OP_DIV = 5'd3;
   localparam logic [CMD_WIDTH-1:0] OP_MOD = 5'd4;
   localparam logic [CMD_WIDTH-1:0] OP_AND = 5'd5;
   localparam logic [CMD_WIDTH-1:0] OP_OR  = 5'd6;
   localparam logic [CMD_WIDTH-1:0] OP_XOR = 5'd7;
   localparam logic [CMD_WIDTH-1:0] OP_NOT = 5'd8;
   localparam logic [CMD_WIDTH-1:0] OP_NEG = 5'd9;
   localparam logic [CMD_WIDTH-1:0] OP_SHL = 5'd10;
   localparam logic [CMD_WIDTH-1:0] OP_SHR = 5'd11;
   localparam logic [CMD_WIDTH-1:0] OP_EQ  = 5'd12;
   localparam logic [CMD_WIDTH-1:0] OP_NE  = 5'd13;
   localparam logic [CMD_WIDTH-1:0] OP_LT  = 5'd14;
   localparam logic [CMD_WIDTH-1:0] OP_GT  = 5'd15;
   localparam logic [CMD_WIDTH-1:0] OP_LE  = 5'd16;
   localparam logic [CMD_WIDTH-1:0] OP_GE  = 5'd17;

   // control that rides along with each request through the pipe
   typedef struct packed {
      logic                 valid;
      logic [CMD_WIDTH-1:0] cmd;
      logic                 zero_div;
   } ctl_type;
endpackage

FILE: design/integer_alu_64.sv
// Pipeline from start to rsp_valid: two input stages, one divider cell per
// quotient bit, one output register.
// Throughput: one request per cycle; busy is always low, results never stall.
// Reset (synchronous) clears all valid bits; in-flight requests are dropped.
// Depends on alu64_pkg, alu64_front, alu64_div_cell.
`timescale 1ns / 1ps
module integer_alu_64 #(
   parameter int DATA_WIDTH = alu64_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [alu64_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  logic [alu64_pkg::COUNT_WIDTH-1:0]  req_operand_a,
   input  logic [alu64_pkg::COUNT_WIDTH-1:0]  req_operand_b,
   output logic                               rsp_valid,
   output logic [alu64_pkg::COUNT_WIDTH-1:0]  rsp_result_value
);
   import alu64_pkg::*;

   ctl_type               ctl_c  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] side_c [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_c  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quo_c  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] div_c  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] res_in;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   ctl_type               last;

   assign busy = 1'b0;

   alu64_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_cmd   (req_cmd),
      .in_a     (req_operand_a),
      .in_b     (req_operand_b),
      .out_ctl  (ctl_c[0]),
      .out_side (side_c[0]),
      .out_a    (quo_c[0]),
      .out_b    (div_c[0])
   );
   assign rem_c[0] = '0;

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      alu64_div_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_ctl   (ctl_c[i]),
         .in_side  (side_c[i]),
         .in_rem   (rem_c[i]),
         .in_quo   (quo_c[i]),
         .in_div   (div_c[i]),
         .out_ctl  (ctl_c[i+1]),
         .out_side (side_c[i+1]),
         .out_rem  (rem_c[i+1]),
         .out_quo  (quo_c[i+1]),
         .out_div  (div_c[i+1])
      );
   end

   // result select; divide by zero gives 0
   assign last = ctl_c[DATA_WIDTH];
   always_comb begin
      case (last.cmd)
         OP_DIV:  res_in = last.zero_div ? '0 : quo_c[DATA_WIDTH];
         OP_MOD:  res_in = last.zero_div ? '0 : rem_c[DATA_WIDTH];
         default: res_in = side_c[DATA_WIDTH];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_value_ff <= res_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = COUNT_WIDTH'(rsp_value_ff);
endmodule

FILE: design/alu64_front.sv
// alu64_front: two input stages; simple ops, shifts, compares, and the
// split multiplier (three half-width partial products, then their sum).
// Depends on alu64_pkg.
`timescale 1ns / 1ps
module alu64_front #(
   parameter int DATA_WIDTH = alu64_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [alu64_pkg::CMD_WIDTH-1:0]       in_cmd,
   input  logic [alu64_pkg::COUNT_WIDTH-1:0]     in_a,
   input  logic [alu64_pkg::COUNT_WIDTH-1:0]     in_b,
   output alu64_pkg::ctl_type                    out_ctl,
   output logic [DATA_WIDTH-1:0]                 out_side,
   output logic [DATA_WIDTH-1:0]                 out_a,
   output logic [DATA_WIDTH-1:0]                 out_b
);
   import alu64_pkg::*;

   localparam int HALF = (DATA_WIDTH + 1) / 2;
   localparam int CW   = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] aw, bw, logic_in, logic_ff;
   logic [HALF-1:0]       al, bl;
   logic [DATA_WIDTH-HALF-1:0] ah, bh;
   logic [2*HALF-1:0]     p0_in, p0_ff;
   logic [DATA_WIDTH-1:0] p1_in, p1_ff, p2_in, p2_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff, cross_sum, prod;
   logic                  shift_big;
   logic                  valid_ff;
   logic [CMD_WIDTH-1:0]  cmd_ff;
   ctl_type               ctl_in, ctl_ff;
   logic [DATA_WIDTH-1:0] side_in, side_ff, a2_ff, b2_ff;

   assign aw = in_a[DATA_WIDTH-1:0];
   assign bw = in_b[DATA_WIDTH-1:0];
   assign al = aw[HALF-1:0];
   assign ah = aw[DATA_WIDTH-1:HALF];
   assign bl = bw[HALF-1:0];
   assign bh = bw[DATA_WIDTH-1:HALF];
   assign shift_big = (in_b >= COUNT_WIDTH'(DATA_WIDTH));

   // partial products, each at most half width by half width
   assign p0_in = (2*HALF)'(al) * (2*HALF)'(bl);
   assign p1_in = DATA_WIDTH'(ah) * DATA_WIDTH'(bl);
   assign p2_in = DATA_WIDTH'(al) * DATA_WIDTH'(bh);

   // simple ops, computed combinationally
   always_comb begin
      case (in_cmd)
         OP_ADD:  logic_in = aw + bw;
         OP_SUB:  logic_in = aw - bw;
         OP_AND:  logic_in = aw & bw;
         OP_OR:   logic_in = aw | bw;
         OP_XOR:  logic_in = aw ^ bw;
         OP_NOT:  logic_in = ~aw;
         OP_NEG:  logic_in = '0 - aw;
         OP_SHL:  logic_in = shift_big ? '0 : (aw << in_b[CW-1:0]);
         OP_SHR:  logic_in = shift_big ? '0 : (aw >> in_b[CW-1:0]);
         OP_EQ:   logic_in = DATA_WIDTH'(aw == bw);
         OP_NE:   logic_in = DATA_WIDTH'(aw != bw);
         OP_LT:   logic_in = DATA_WIDTH'(aw < bw);
         OP_GT:   logic_in = DATA_WIDTH'(aw > bw);
         OP_LE:   logic_in = DATA_WIDTH'(aw <= bw);
         OP_GE:   logic_in = DATA_WIDTH'(aw >= bw);
         default: logic_in = '0;
      endcase
   end

   // stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      cmd_ff   <= in_cmd;
      logic_ff <= logic_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      a_ff     <= aw;
      b_ff     <= bw;
   end

   // product sum
   assign cross_sum = p1_ff + p2_ff;
   assign prod      = p0_ff[DATA_WIDTH-1:0] + (cross_sum << HALF);

   always_comb begin
      ctl_in.valid    = valid_ff;
      ctl_in.cmd      = cmd_ff;
      ctl_in.zero_div = (b_ff == '0);
      side_in = (cmd_ff == OP_MUL) ? prod : logic_ff;
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.cmd      <= ctl_in.cmd;
      ctl_ff.zero_div <= ctl_in.zero_div;
      side_ff <= side_in;
      a2_ff   <= a_ff;
      b2_ff   <= b_ff;
   end

   assign out_ctl  = ctl_ff;
   assign out_side = side_ff;
   assign out_a    = a2_ff;
   assign out_b    = b2_ff;
endmodule

FILE: design/alu64_div_cell.sv
// alu64_div_cell: one restoring-divide step, registered; also carries the
// request's control and side result to the next cell. Depends on alu64_pkg.
`timescale 1ns / 1ps
module alu64_div_cell #(
   parameter int DATA_WIDTH = alu64_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alu64_pkg::ctl_type    in_ctl,
   input  logic [DATA_WIDTH-1:0] in_side,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [DATA_WIDTH-1:0] in_quo,
   input  logic [DATA_WIDTH-1:0] in_div,
   output alu64_pkg::ctl_type    out_ctl,
   output logic [DATA_WIDTH-1:0] out_side,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_quo,
   output logic [DATA_WIDTH-1:0] out_div
);
   import alu64_pkg::*;

   logic [DATA_WIDTH:0]   trial;
   logic                  ge;
   logic [DATA_WIDTH-1:0] rem_in, quo_in;
   ctl_type               ctl_ff;
   logic [DATA_WIDTH-1:0] side_ff, rem_ff, quo_ff, div_ff;

   // shift next dividend bit in, subtract if it fits (full width, no loss)
   assign trial  = {in_rem, in_quo[DATA_WIDTH-1]};
   assign ge     = (trial >= {1'b0, in_div});
   assign rem_in = ge ? DATA_WIDTH'(trial - {1'b0, in_div}) : trial[DATA_WIDTH-1:0];
   assign quo_in = {in_quo[DATA_WIDTH-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= in_ctl.valid;
      end
      ctl_ff.cmd      <= in_ctl.cmd;
      ctl_ff.zero_div <= in_ctl.zero_div;
      side_ff <= in_side;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= in_div;
   end

   assign out_ctl  = ctl_ff;
   assign out_side = side_ff;
   assign out_rem  = rem_ff;
   assign out_quo  = quo_ff;
   assign out_div  = div_ff;
endmodule
